// File: sv/esc_pkg.sv
package esc_pkg;

	localparam int unsigned SECS_W  = 32;
	localparam int unsigned DAYS_W  = 16;
	localparam int unsigned CNT_W   = 4;

	localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
	localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
	localparam logic [31:0] SECS_PER_MIN  = 32'd60;
	localparam logic [31:0] DAYS_PER_WEEK = 32'd7;

	// top quotient bit of each long division
	localparam logic [CNT_W-1:0] DAY_TOP_BIT  = 4'd15;
	localparam logic [CNT_W-1:0] HOUR_TOP_BIT = 4'd4;
	localparam logic [CNT_W-1:0] MIN_TOP_BIT  = 4'd5;
	localparam logic [CNT_W-1:0] WDAY_TOP_BIT = 4'd12;

	// day zero was a thursday
	localparam logic [DAYS_W:0] EPOCH_WEEKDAY = 17'd4;

	// years counted from 1900
	localparam logic [7:0] EPOCH_YEAR_OFS  = 8'd70;
	localparam logic [7:0] YEAR_1900       = 8'd0;
	localparam logic [7:0] YEAR_2100       = 8'd200;

	localparam logic [31:0] DAYS_LEAP_YEAR   = 32'd366;
	localparam logic [31:0] DAYS_COMMON_YEAR = 32'd365;

	localparam logic [3:0] MONTH_JAN = 4'd0;
	localparam logic [3:0] MONTH_DEC = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAY,
		ST_HOUR,
		ST_MIN,
		ST_WDAY,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	typedef struct packed {
		state_t           phase;
		logic [CNT_W-1:0] shift;
		logic             leap;
		logic [3:0]       mon;
	} alu_ctrl_t;

	// gregorian rule for years 1900..2155 given as offset from 1900
	function automatic logic is_leap(input logic [7:0] y);
		is_leap = (y[1:0] == 2'b00) && (y != YEAR_1900) && (y != YEAR_2100);
	endfunction

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
		unique case (mon)
			4'd1:                      month_len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   month_len = 5'd30;
			default:                   month_len = 5'd31;
		endcase
	endfunction

endpackage

// File: sv/esc_alu.sv
module esc_alu (
	input  esc_pkg::alu_ctrl_t          ctrl,
	input  logic [esc_pkg::SECS_W-1:0]  work,
	input  logic [esc_pkg::DAYS_W-1:0]  days,
	output logic [esc_pkg::SECS_W-1:0]  diff,
	output logic                        ge
);
	import esc_pkg::*;

	logic [SECS_W-1:0] op_a;
	logic [SECS_W-1:0] op_b;
	logic [SECS_W:0]   sub;

	// operand select for the one shared compare-subtract
	always_comb begin
		op_a = work;
		op_b = '0;
		unique case (ctrl.phase)
			ST_DAY:   op_b = SECS_PER_DAY << ctrl.shift;
			ST_HOUR:  op_b = SECS_PER_HOUR << ctrl.shift;
			ST_MIN:   op_b = SECS_PER_MIN << ctrl.shift;
			ST_WDAY:  op_b = DAYS_PER_WEEK << ctrl.shift;
			ST_YEAR: begin
				op_a = {{(SECS_W-DAYS_W){1'b0}}, days};
				op_b = ctrl.leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
			end
			ST_MONTH: begin
				op_a = {{(SECS_W-DAYS_W){1'b0}}, days};
				op_b = {27'd0, month_len(ctrl.leap, ctrl.mon)};
			end
			default:  op_b = '0;
		endcase
	end

	assign sub  = {1'b0, op_a} - {1'b0, op_b};
	assign diff = sub[SECS_W-1:0];
	assign ge   = ~sub[SECS_W];

endmodule

// File: sv/epoch_seconds_to_calendar_top.sv
// epoch seconds to utc calendar converter. pulse start with epoch_seconds while busy
// is low; the value is taken as an unsigned 32-bit count of seconds since
// 1970-01-01 00:00:00 utc and no time zone is applied. every field of the result
// appears together for exactly one cycle with done high, and there is no way to hold
// it off, so the receiver must capture it in that cycle. busy rises the cycle after
// the transaction is taken and stays high until done has been shown, so a new start
// can be taken only once done is over. one compare-subtract unit does all the work
// in sequence: 16 steps split off the day count, 5 and 6 steps give hours and
// minutes, 13 steps give the weekday, then the year walk takes one step per year
// past 1970 plus one, and the month walk one step per month plus one. busy stays high
// through the whole conversion, with done in its last cycle. reset clears the
// sequencer only.
module epoch_seconds_to_calendar_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	output logic        done,
	output logic [5:0]  second_of_minute,
	output logic [5:0]  minute_of_hour,
	output logic [4:0]  hour_of_day,
	output logic [2:0]  weekday,
	output logic [7:0]  years_since_1900,
	output logic [8:0]  day_of_year,
	output logic [3:0]  month_index,
	output logic [4:0]  day_of_month
);
	import esc_pkg::*;

	state_t state_q, state_d;

	// sequencer and working registers
	logic [CNT_W-1:0]  cnt_q;
	logic [SECS_W-1:0] work_q;   // remainder of the running long division
	logic [DAYS_W-1:0] days_q;   // whole days, then days left in year and month
	logic [5:0]        sec_q;
	logic [5:0]        min_q;
	logic [4:0]        hour_q;
	logic [2:0]        wday_q;
	logic [7:0]        year_q;
	logic [8:0]        yday_q;
	logic [3:0]        mon_q;
	logic [4:0]        dom_q;

	alu_ctrl_t         alu_ctrl;
	logic [SECS_W-1:0] alu_diff;
	logic              alu_ge;
	logic [SECS_W-1:0] rem_next;
	logic              last_bit;
	logic              accept;

	assign accept   = start && (state_q == ST_IDLE);
	assign last_bit = (cnt_q == '0);
	assign rem_next = alu_ge ? alu_diff : work_q;

	assign alu_ctrl.phase = state_q;
	assign alu_ctrl.shift = cnt_q;
	assign alu_ctrl.leap  = is_leap(year_q);
	assign alu_ctrl.mon   = mon_q;

	esc_alu u_alu (
		.ctrl (alu_ctrl),
		.work (work_q),
		.days (days_q),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start)    state_d = ST_DAY;
			ST_DAY:   if (last_bit) state_d = ST_HOUR;
			ST_HOUR:  if (last_bit) state_d = ST_MIN;
			ST_MIN:   if (last_bit) state_d = ST_WDAY;
			ST_WDAY:  if (last_bit) state_d = ST_YEAR;
			ST_YEAR:  if (!alu_ge)  state_d = ST_MONTH;
			ST_MONTH: if (!alu_ge || mon_q == MONTH_DEC) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					work_q <= epoch_seconds;
					days_q <= '0;
					hour_q <= '0;
					min_q  <= '0;
					cnt_q  <= DAY_TOP_BIT;
				end
			end
			ST_DAY: begin
				work_q <= rem_next;
				if (alu_ge) days_q[cnt_q] <= 1'b1;
				cnt_q  <= last_bit ? HOUR_TOP_BIT : cnt_q - 1'b1;
			end
			ST_HOUR: begin
				work_q <= rem_next;
				if (alu_ge) hour_q[cnt_q[2:0]] <= 1'b1;
				cnt_q  <= last_bit ? MIN_TOP_BIT : cnt_q - 1'b1;
			end
			ST_MIN: begin
				if (alu_ge) min_q[cnt_q[2:0]] <= 1'b1;
				if (last_bit) begin
					// remainder is the seconds; reload with the shifted day count
					sec_q  <= rem_next[5:0];
					work_q <= {{(SECS_W-DAYS_W-1){1'b0}}, {1'b0, days_q} + EPOCH_WEEKDAY};
					cnt_q  <= WDAY_TOP_BIT;
				end else begin
					work_q <= rem_next;
					cnt_q  <= cnt_q - 1'b1;
				end
			end
			ST_WDAY: begin
				work_q <= rem_next;
				cnt_q  <= cnt_q - 1'b1;
				if (last_bit) begin
					wday_q <= rem_next[2:0];
					year_q <= EPOCH_YEAR_OFS;
				end
			end
			ST_YEAR: begin
				if (alu_ge) begin
					days_q <= alu_diff[DAYS_W-1:0];
					year_q <= year_q + 1'b1;
				end else begin
					yday_q <= days_q[8:0];
					mon_q  <= MONTH_JAN;
				end
			end
			ST_MONTH: begin
				if (alu_ge && mon_q != MONTH_DEC) begin
					days_q <= alu_diff[DAYS_W-1:0];
					mon_q  <= mon_q + 1'b1;
				end else begin
					dom_q  <= days_q[4:0] + 5'd1;
				end
			end
			ST_DONE: begin
				cnt_q <= cnt_q;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// result fields straight from the working registers
	assign second_of_minute = sec_q;
	assign minute_of_hour   = min_q;
	assign hour_of_day      = hour_q;
	assign weekday          = wday_q;
	assign years_since_1900 = year_q;
	assign day_of_year      = yday_q;
	assign month_index      = mon_q;
	assign day_of_month     = dom_q;

	// a result only ever closes a conversion that was running
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a running conversion");

	// a taken transaction starts the sequencer on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not start the sequencer");

	// time of day fields come out of the divisions in range
	a_tod_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hour_of_day < 5'd24 && minute_of_hour < 6'd60
			&& second_of_minute < 6'd60 && weekday < 3'd7))
		else $error("time of day field out of range");

	// month walk ends on a real month and day
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month_index <= MONTH_DEC && day_of_month != 5'd0
			&& day_of_year < 9'd366))
		else $error("date field out of range");

endmodule

// File: sim/epoch_seconds_to_calendar_top_tb.sv
module epoch_seconds_to_calendar_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one broken-down date as the converter returns it
	typedef struct packed {
		logic [5:0] second_of_minute;
		logic [5:0] minute_of_hour;
		logic [4:0] hour_of_day;
		logic [2:0] weekday;
		logic [7:0] years_since_1900;
		logic [8:0] day_of_year;
		logic [3:0] month_index;
		logic [4:0] day_of_month;
	} cal_t;

	localparam int unsigned DAY_SECS     = 86400;
	localparam int unsigned HOUR_SECS    = 3600;
	localparam int unsigned MIN_SECS     = 60;
	localparam int unsigned FIRST_YEAR   = 1970;
	localparam int unsigned TM_BASE_YEAR = 1900;
	localparam int unsigned THURSDAY     = 4;
	localparam int unsigned FEBRUARY     = 1;
	localparam int unsigned DECEMBER     = 11;
	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	localparam int RANDOM_ITEMS = 1380;
	localparam int QUIET_TAIL   = 150;  // last transactions get no random idle bursts
	localparam int DRAIN_EVERY  = 97;   // sender waits for the result now and then
	localparam int STALL_LIMIT  = 2000; // well above the longest conversion plus the longest idle burst
	localparam int END_CYCLES   = 250;
	localparam int REPORT_MAX   = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] epoch_seconds = '0;
	logic        busy;
	logic        done;
	logic [5:0]  second_of_minute;
	logic [5:0]  minute_of_hour;
	logic [4:0]  hour_of_day;
	logic [2:0]  weekday;
	logic [7:0]  years_since_1900;
	logic [8:0]  day_of_year;
	logic [3:0]  month_index;
	logic [4:0]  day_of_month;

	epoch_seconds_to_calendar_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.epoch_seconds    (epoch_seconds),
		.done             (done),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.weekday          (weekday),
		.years_since_1900 (years_since_1900),
		.day_of_year      (day_of_year),
		.month_index      (month_index),
		.day_of_month     (day_of_month)
	);

	// seconds still to be offered, and dates still to come back
	logic [31:0] pending_seconds [$];
	cal_t        expected_dates [$];

	int item_total = 0;
	int sent_count = 0;
	int results_seen = 0;  // counted by the driver from done, for the drain pause
	int gap_left = 0;
	int error_count = 0;
	int stall_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// gregorian rule on the full year number
	function automatic bit gregorian_leap(input int unsigned year);
		return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
	endfunction

	// converts a second count into the date that the converter must return
	function automatic cal_t calendar_of(input logic [31:0] secs);
		int unsigned tod, days, year, mon, mlen;
		bit          leap;
		cal_t        c;
		tod  = secs % DAY_SECS;
		days = secs / DAY_SECS;
		c.second_of_minute = 6'(tod % MIN_SECS);
		c.minute_of_hour   = 6'((tod % HOUR_SECS) / MIN_SECS);
		c.hour_of_day      = 5'(tod / HOUR_SECS);
		c.weekday          = 3'((days + THURSDAY) % 7);
		// walk whole years forward from 1970
		year = FIRST_YEAR;
		leap = gregorian_leap(year);
		while (days >= (leap ? 366 : 365)) begin
			days -= leap ? 366 : 365;
			year++;
			leap = gregorian_leap(year);
		end
		c.years_since_1900 = 8'(year - TM_BASE_YEAR);
		c.day_of_year      = 9'(days);
		// then whole months, february grows by one day in a leap year
		mon = 0;
		mlen = MONTH_DAYS[0];
		while (mon < DECEMBER && days >= mlen) begin
			days -= mlen;
			mon++;
			mlen = MONTH_DAYS[mon] + ((leap && mon == FEBRUARY) ? 1 : 0);
		end
		c.month_index  = 4'(mon);
		c.day_of_month = 5'(days + 1);
		return c;
	endfunction

	function automatic string cal_text(input cal_t c);
		return $sformatf("y+1900=%0d yday=%0d mon=%0d mday=%0d %0d:%0d:%0d wday=%0d",
			c.years_since_1900, c.day_of_year, c.month_index, c.day_of_month,
			c.hour_of_day, c.minute_of_hour, c.second_of_minute, c.weekday);
	endfunction

	// stimulus: directed corner dates, then a random mix
	initial begin
		longint      boundary;
		int unsigned days;
		int unsigned year;
		// epoch itself, one second in, minute and hour and day edges
		pending_seconds.push_back(32'd0);
		pending_seconds.push_back(32'd1);
		pending_seconds.push_back(32'd59);
		pending_seconds.push_back(32'd60);
		pending_seconds.push_back(32'd3599);
		pending_seconds.push_back(32'd3600);
		pending_seconds.push_back(32'd86399);
		pending_seconds.push_back(32'd86400);
		// march 1 1971 and the last second of 1971
		pending_seconds.push_back(32'd36633600);
		pending_seconds.push_back(32'd63071999);
		// century turn: 1999 to 2000, 2000 leap day, last second of 2000 (day 365)
		pending_seconds.push_back(32'd946684799);
		pending_seconds.push_back(32'd946684800);
		pending_seconds.push_back(32'd951782400);
		pending_seconds.push_back(32'd978307199);
		// largest value software sees as positive, then the first one it sees as negative
		pending_seconds.push_back(32'h7FFF_FFFF);
		pending_seconds.push_back(32'h8000_0000);
		// 2100 is not a leap year: feb 28 then mar 1
		pending_seconds.push_back(32'd4107456000);
		pending_seconds.push_back(32'd4107542400);
		// alternating bit patterns and the full-scale value
		pending_seconds.push_back(32'hAAAA_AAAA);
		pending_seconds.push_back(32'h5555_5555);
		pending_seconds.push_back(32'hFFFF_FFFF);

		repeat (RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: pending_seconds.push_back($urandom);
				4, 5: begin
					// a second or two around new year of a random year
					year = $urandom_range(FIRST_YEAR + 1, 2106);
					days = 0;
					for (int unsigned y = FIRST_YEAR; y < year; y++)
						days += gregorian_leap(y) ? 366 : 365;
					boundary = longint'(days) * DAY_SECS + $urandom_range(0, 3) - 2;
					pending_seconds.push_back(boundary[31:0]);
				end
				6, 7: begin
					// a random day near midnight at either end
					days = $urandom_range(0, 49710);
					boundary = longint'(days) * DAY_SECS;
					if ($urandom_range(0, 1))
						boundary += $urandom_range(0, 2);
					else
						boundary += DAY_SECS - 1 - $urandom_range(0, 2);
					pending_seconds.push_back(boundary[31:0]);
				end
				8: pending_seconds.push_back($urandom_range(0, 100000));
				default: begin
					// early 2100, around the skipped leap day
					days = $urandom_range(47482, 47545);
					boundary = longint'(days) * DAY_SECS + $urandom_range(0, DAY_SECS - 1);
					pending_seconds.push_back(boundary[31:0]);
				end
			endcase
		end
		item_total = pending_seconds.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (sent_count == item_total && expected_dates.size() == 0);
		repeat (END_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("epoch_seconds_to_calendar_top verification clean");
		else
			$display("epoch_seconds_to_calendar_top verification failed");
		$finish;
	end

	// driver: a transaction is taken at an edge with start high and busy low;
	// start may stay high through busy with the next value waiting
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start         <= 1'b0;
			epoch_seconds <= '0;
		end else begin
			if (done)
				results_seen++;
			if (start && !busy) begin
				expected_dates.push_back(calendar_of(epoch_seconds));
				sent_count++;
				// a random idle burst after this one, none in the closing stretch
				if (sent_count < item_total - QUIET_TAIL && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 18);
			end
			if (start && busy) begin
				// offered transaction still waiting for the converter
			end else if (gap_left > 0 || pending_seconds.size() == 0 ||
					(sent_count % DRAIN_EVERY == 0 && results_seen != sent_count)) begin
				// idle: burst, nothing left, or a full drain before going on
				start <= 1'b0;
				if (gap_left > 0 && !busy)
					gap_left--;
			end else begin
				start         <= 1'b1;
				epoch_seconds <= pending_seconds.pop_front();
			end
		end
	end

	// monitor: done marks the one cycle in which the result can be captured
	always @(posedge clk) begin
		cal_t got;
		cal_t want;
		bit   bad;
		if (arst_n && done) begin
			got = '{second_of_minute, minute_of_hour, hour_of_day, weekday,
				years_since_1900, day_of_year, month_index, day_of_month};
			if (expected_dates.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_MAX)
					$display("%0t: result with no transaction outstanding: %s",
						$realtime, cal_text(got));
			end else begin
				want = expected_dates.pop_front();
				bad = (got.second_of_minute !== want.second_of_minute) ||
					(got.minute_of_hour !== want.minute_of_hour) ||
					(got.hour_of_day !== want.hour_of_day) ||
					(got.weekday !== want.weekday) ||
					(got.years_since_1900 !== want.years_since_1900) ||
					(got.day_of_year !== want.day_of_year) ||
					(got.month_index !== want.month_index) ||
					(got.day_of_month !== want.day_of_month);
				if (bad) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$display("%0t: mismatch\n  expected %s\n  actual   %s",
							$realtime, cal_text(want), cal_text(got));
				end
			end
		end
	end

	// watchdog on cycles with no transaction and no result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("epoch_seconds_to_calendar_top verification failed");
				$finish;
			end
		end
	end

endmodule
